### rtl/core/lrpp_pkg.sv
// ============================================================================
// lrpp_pkg - shared types and constants of the light reply packet parser
// Holds the byte codes of the reply packet prefixes, the reply kind codes
// and the record types that pass between the parser stages.
// ============================================================================
package lrpp_pkg;

    // Bytes of the reply prefixes and the channel field markers.
    localparam logic [7:0] BYTE_HEAD        = 8'hd2;
    localparam logic [7:0] BYTE_ACK         = 8'ha1;
    localparam logic [7:0] BYTE_CHANNEL_ACK = 8'ha6;
    localparam logic [7:0] BYTE_STATUS      = 8'hb0;
    localparam logic [7:0] BYTE_STATUS_LEN  = 8'h0e;
    localparam logic [7:0] BYTE_ZERO        = 8'h00;
    localparam logic [7:0] BYTE_ONE         = 8'h01;
    localparam logic [7:0] BYTE_MARK_START  = 8'h02;
    localparam logic [7:0] BYTE_MARK_END    = 8'hf5;
    localparam logic [7:0] BYTE_VALUE_TAG   = 8'h18;
    localparam logic [7:0] BYTE_FIRST_ID    = 8'h03;

    // Channel levels are percentages.
    localparam logic [7:0] LEVEL_MAX  = 8'd100;
    localparam int         CHANNELS   = 5;

    // Rounded division by five: (x * 205) >> 10 is exact for x below 1024.
    localparam logic [7:0] DIV5_MUL   = 8'd205;
    localparam int         DIV5_SHIFT = 10;

    // Reply kind codes.
    localparam logic [2:0] KIND_UNKNOWN     = 3'd0;
    localparam logic [2:0] KIND_MANUAL_ACK  = 3'd1;
    localparam logic [2:0] KIND_AUTO_ACK    = 3'd2;
    localparam logic [2:0] KIND_CHANNEL_ACK = 3'd3;
    localparam logic [2:0] KIND_STATUS      = 3'd4;

    // Light mode codes.
    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_MANUAL  = 2'd1;
    localparam logic [1:0] MODE_AUTO    = 2'd2;

    // One received byte as held in the input register.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } rx_item_t;

    // One classified reply.
    typedef struct packed {
        logic [2:0] reply_kind;
        logic       status_ok;
        logic [1:0] light_mode;
        logic [6:0] pink_level;
        logic [6:0] blue_level;
        logic [6:0] cold_white_level;
        logic [6:0] white_level;
        logic [6:0] warm_white_level;
        logic [6:0] average_level;
    } reply_t;

endpackage

### rtl/core/lrpp_if.sv
// ============================================================================
// lrpp_if - channel interfaces of the light reply packet parser
// A byte channel and a reply channel, each with valid, ready and payload.
// ============================================================================
interface lrpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;

    modport source (output valid, output rx_byte, output end_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface lrpp_reply_if;
    logic       valid;
    logic       ready;
    logic [2:0] reply_kind;
    logic       status_ok;
    logic [1:0] light_mode;
    logic [6:0] pink_level;
    logic [6:0] blue_level;
    logic [6:0] cold_white_level;
    logic [6:0] white_level;
    logic [6:0] warm_white_level;
    logic [6:0] average_level;

    modport source (
        output valid, output reply_kind, output status_ok, output light_mode,
        output pink_level, output blue_level, output cold_white_level,
        output white_level, output warm_white_level, output average_level,
        input ready
    );
    modport sink (
        input valid, input reply_kind, input status_ok, input light_mode,
        input pink_level, input blue_level, input cold_white_level,
        input white_level, input warm_white_level, input average_level,
        output ready
    );
endinterface

### rtl/core/lrpp_input_stage.sv
// ============================================================================
// lrpp_input_stage - input register of the reply parser
// Captures one byte item per cycle and holds it until the parser takes it.
// ============================================================================
module lrpp_input_stage
    import lrpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lrpp_rx_if.sink  rx,
    input  logic     take,
    output logic     item_valid,
    output rx_item_t item
);

    logic     valid_reg;
    rx_item_t item_reg;

    // The register is free when empty or when its item leaves this cycle.
    assign rx.ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            item_reg.rx_byte       <= rx.rx_byte;
            item_reg.end_of_packet <= rx.end_of_packet;
        end
    end

endmodule

### rtl/core/lrpp_parse_core.sv
// ============================================================================
// lrpp_parse_core - per-packet parsing state of the reply parser
// Updates the prefix match, marker search and channel field state for the
// held byte, and builds the reply record on the final byte of a packet.
// ============================================================================
module lrpp_parse_core
    import lrpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  rx_item_t item,
    input  logic     out_space,
    output logic     take,
    output logic     reply_load,
    output reply_t   reply
);

    // Parse phases.
    localparam logic [2:0] PH_SEARCH   = 3'd0;
    localparam logic [2:0] PH_ID       = 3'd1;
    localparam logic [2:0] PH_AFTER_ID = 3'd2;
    localparam logic [2:0] PH_VALUE    = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;
    localparam logic [2:0] PH_FAIL     = 3'd5;

    localparam logic [3:0] POS_SAT    = 4'd8;
    localparam logic [2:0] FIELD_LAST = 3'(CHANNELS);

    logic [3:0] pos_reg,   pos_next;
    logic [3:0] flags_reg, flags_next;
    logic       prev_mark_reg, prev_mark_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] field_reg, field_next;
    logic [1:0] mode_reg,  mode_next;
    logic [8:0] sum_reg,   sum_next;
    logic [6:0] level_reg  [CHANNELS];
    logic [6:0] level_next [CHANNELS];

    logic [7:0]  b;
    logic        last;
    logic [6:0]  clamped;
    logic        take_val;
    logic [9:0]  sum_round;
    logic [17:0] avg_prod;
    logic [2:0]  kind;

    assign b    = item.rx_byte;
    assign last = item.end_of_packet;

    // A byte moves on unless it closes a packet while the result slot is full.
    assign take       = item_valid && (!last || out_space);
    assign reply_load = take && last;

    assign clamped = (b > LEVEL_MAX) ? LEVEL_MAX[6:0] : b[6:0];

    // Prefix match, byte count and mode byte.
    always_comb
    begin
        flags_next = flags_reg;
        mode_next  = mode_reg;
        unique case (pos_reg)
            4'd0:
            begin
                if (b != BYTE_HEAD) flags_next = 4'b0000;
            end
            4'd1:
            begin
                if (b != BYTE_ACK) flags_next[1:0] = 2'b00;
                if (b != BYTE_CHANNEL_ACK) flags_next[2] = 1'b0;
                if (b != BYTE_STATUS) flags_next[3] = 1'b0;
            end
            4'd2:
            begin
                if (b != BYTE_ONE) flags_next[1:0] = 2'b00;
                if (b != BYTE_ZERO) flags_next[3] = 1'b0;
            end
            4'd3:
            begin
                if (b != BYTE_ZERO) flags_next[0] = 1'b0;
                if (b != BYTE_ONE) flags_next[1] = 1'b0;
                if (b != BYTE_STATUS_LEN) flags_next[3] = 1'b0;
            end
            4'd4:
            begin
                if (b != BYTE_ONE) flags_next[3] = 1'b0;
            end
            4'd5:
            begin
                mode_next = (b == BYTE_ZERO) ? MODE_MANUAL :
                            (b == BYTE_ONE)  ? MODE_AUTO : MODE_UNKNOWN;
            end
            default:
            begin
            end
        endcase
        pos_next = (pos_reg < POS_SAT) ? pos_reg + 4'd1 : POS_SAT;
    end

    // Marker search and channel field parsing.
    always_comb
    begin
        phase_next     = phase_reg;
        field_next     = field_reg;
        prev_mark_next = prev_mark_reg;
        take_val       = 1'b0;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (prev_mark_reg && b == BYTE_MARK_END)
                begin
                    phase_next = PH_ID;
                    field_next = 3'd0;
                end
                else
                begin
                    prev_mark_next = (b == BYTE_MARK_START);
                end
            end
            PH_ID:
            begin
                phase_next = (field_reg < FIELD_LAST &&
                              b == BYTE_FIRST_ID + {5'd0, field_reg}) ? PH_AFTER_ID : PH_FAIL;
            end
            PH_AFTER_ID:
            begin
                if (b == BYTE_VALUE_TAG) phase_next = PH_VALUE;
                else take_val = 1'b1;
            end
            PH_VALUE:
            begin
                take_val = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (take_val)
        begin
            if (field_reg < FIELD_LAST) field_next = field_reg + 3'd1;
            phase_next = (field_next >= FIELD_LAST) ? PH_DONE : PH_ID;
        end
    end

    // Channel level write and running sum.
    always_comb
    begin
        sum_next = sum_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            level_next[i] = level_reg[i];
        end
        if (take_val && field_reg < FIELD_LAST)
        begin
            level_next[field_reg] = clamped;
            sum_next              = sum_reg + {2'd0, clamped};
        end
    end

    // Reply record; the sum stays at or below 500, so the product is exact.
    assign sum_round = {1'b0, sum_next} + 10'd2;
    assign avg_prod  = sum_round * DIV5_MUL;

    always_comb
    begin
        kind = KIND_UNKNOWN;
        if (pos_next >= 4'd4)
        begin
            if (flags_next[0]) kind = KIND_MANUAL_ACK;
            else if (flags_next[1]) kind = KIND_AUTO_ACK;
            else if (flags_next[2]) kind = KIND_CHANNEL_ACK;
            else if (flags_next[3] && pos_next >= 4'd5) kind = KIND_STATUS;
        end
        reply            = '0;
        reply.reply_kind = kind;
        if (kind == KIND_STATUS && pos_next >= POS_SAT)
        begin
            reply.status_ok        = (phase_next == PH_DONE);
            reply.light_mode       = mode_next;
            reply.pink_level       = level_next[0];
            reply.blue_level       = level_next[1];
            reply.cold_white_level = level_next[2];
            reply.white_level      = level_next[3];
            reply.warm_white_level = level_next[4];
            reply.average_level    = (phase_next == PH_DONE) ?
                                     avg_prod[DIV5_SHIFT +: 7] : 7'd0;
        end
    end

    // State registers; a packet's final byte returns them to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            flags_reg     <= 4'b1111;
            prev_mark_reg <= 1'b0;
            phase_reg     <= PH_SEARCH;
            field_reg     <= 3'd0;
            mode_reg      <= MODE_UNKNOWN;
            sum_reg       <= 9'd0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                level_reg[i] <= 7'd0;
            end
        end
        else if (take)
        begin
            if (last)
            begin
                pos_reg       <= 4'd0;
                flags_reg     <= 4'b1111;
                prev_mark_reg <= 1'b0;
                phase_reg     <= PH_SEARCH;
                field_reg     <= 3'd0;
                mode_reg      <= MODE_UNKNOWN;
                sum_reg       <= 9'd0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    level_reg[i] <= 7'd0;
                end
            end
            else
            begin
                pos_reg       <= pos_next;
                flags_reg     <= flags_next;
                prev_mark_reg <= prev_mark_next;
                phase_reg     <= phase_next;
                field_reg     <= field_next;
                mode_reg      <= mode_next;
                sum_reg       <= sum_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    level_reg[i] <= level_next[i];
                end
            end
        end
    end

    // The field counter never passes the channel count.
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= FIELD_LAST)
        else $error("field counter out of range");

    // A finished parse has seen every channel.
    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> field_reg == FIELD_LAST)
        else $error("parse done before all channels");

    // A final byte returns the packet state to its start.
    a_packet_restart: assert property (@(posedge clk) disable iff (!rst_n)
        reply_load |=> (pos_reg == 4'd0 && phase_reg == PH_SEARCH && sum_reg == 9'd0))
        else $error("packet state not cleared after final byte");

    // The running sum matches the stored levels.
    a_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg == {2'd0, level_reg[0]} + {2'd0, level_reg[1]} + {2'd0, level_reg[2]}
                 + {2'd0, level_reg[3]} + {2'd0, level_reg[4]})
        else $error("running sum differs from levels");

endmodule

### rtl/core/lrpp_result_stage.sv
// ============================================================================
// lrpp_result_stage - result register of the reply parser
// Holds one reply item until the consumer takes it.
// ============================================================================
module lrpp_result_stage
    import lrpp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  reply_t        reply_in,
    output logic          out_space,
    lrpp_reply_if.source  reply
);

    logic   valid_reg;
    reply_t data_reg;

    // A new reply fits when the slot is empty or drains this cycle.
    assign out_space = !valid_reg || reply.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_space)
        begin
            valid_reg <= load;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= reply_in;
        end
    end

    assign reply.valid            = valid_reg;
    assign reply.reply_kind       = data_reg.reply_kind;
    assign reply.status_ok        = data_reg.status_ok;
    assign reply.light_mode       = data_reg.light_mode;
    assign reply.pink_level       = data_reg.pink_level;
    assign reply.blue_level       = data_reg.blue_level;
    assign reply.cold_white_level = data_reg.cold_white_level;
    assign reply.white_level      = data_reg.white_level;
    assign reply.warm_white_level = data_reg.warm_white_level;
    assign reply.average_level    = data_reg.average_level;

    // A load only happens when there is room for it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_space)
        else $error("reply loaded into a full slot");

    // Only a status reply can report a complete parse.
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid && reply.status_ok |-> reply.reply_kind == KIND_STATUS)
        else $error("status_ok on a non-status reply");

    // An average is reported only with a complete parse.
    a_avg_ok: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid && !reply.status_ok |-> reply.average_level == 7'd0)
        else $error("average without a complete parse");

endmodule

### rtl/core/light_reply_packet_parser.sv
// ============================================================================
// light_reply_packet_parser - reply packet parser for a lighting device
//
//   Channel   Dir   Payload                                   Per item
//   rx        in    rx_byte[7:0], end_of_packet               one packet byte
//   reply     out   reply_kind, status_ok, light_mode,        one per packet
//                   five channel levels, average_level
//
// One byte is taken every cycle; the parse state updates in a single pass.
// A reply passes through the input register and the reply register after the final byte of its packet is accepted.
// The input register only stalls when a final byte meets a full reply slot.
// Reset is asynchronous and active low and needs no clearing pass.
// ============================================================================
module light_reply_packet_parser
    import lrpp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lrpp_rx_if.sink      rx,
    lrpp_reply_if.source reply
);

    logic     item_valid;
    rx_item_t item;
    logic     take;
    logic     out_space;
    logic     reply_load;
    reply_t   reply_data;

    // Input register.
    lrpp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parsing state and reply build.
    lrpp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .take       (take),
        .reply_load (reply_load),
        .reply      (reply_data)
    );

    // Reply register.
    lrpp_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (reply_load),
        .reply_in  (reply_data),
        .out_space (out_space),
        .reply     (reply)
    );

endmodule

### tb/tb_light_reply_packet_parser.sv
// ============================================================================
// tb_light_reply_packet_parser - self-checking testbench of the reply parser
// Feeds reply packets one byte at a time: a short directed set of acks,
// short packets and status replies, then mostly well-formed status replies
// with random contents, mixed with acks and noise packets. A predictor in
// the testbench classifies each packet as its bytes are accepted, and every
// reply from the parser is compared, field by field, with the oldest
// prediction. Both channels idle and stall in random bursts.
// ============================================================================
module tb_light_reply_packet_parser;
    import lrpp_pkg::*;

    // Progress of the channel field scan inside a status reply.
    typedef enum logic [2:0] {
        SEEK_MARK,
        WANT_ID,
        AFTER_ID,
        WANT_VALUE,
        FIELDS_DONE,
        FIELDS_BAD
    } field_scan_t;

    // Bit positions of the prefix candidates that are still possible.
    localparam int HIT_MANUAL  = 0;
    localparam int HIT_AUTO    = 1;
    localparam int HIT_CHANNEL = 2;
    localparam int HIT_STATUS  = 3;

    localparam int RANDOM_BYTES  = 1000;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int RESET_CYCLES  = 6;

    logic clk;
    logic rst_n;

    lrpp_rx_if    rx_ch ();
    lrpp_reply_if reply_ch ();

    light_reply_packet_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .reply (reply_ch)
    );

    // Bytes waiting to be sent and replies waiting to arrive.
    rx_item_t   pending_bytes[$];
    reply_t     expected_replies[$];
    logic [7:0] pkt[$];

    // Predictor state of the packet being received.
    logic [3:0]  pos_count;
    logic [3:0]  prefix_hits;
    logic        saw_mark_start;
    field_scan_t scan;
    logic [2:0]  field_idx;
    logic [1:0]  mode_code;
    logic [6:0]  levels[CHANNELS];

    // Driver and monitor bookkeeping.
    logic     byte_taken;
    rx_item_t next_item;
    int       send_gap;
    int       stall_left;
    int       error_count;
    int       packets_built;
    int       replies_checked;
    int       complete_status;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Return the predictor to its state at the start of a packet.
    task automatic clear_scan();
        pos_count      = '0;
        prefix_hits    = '1;
        saw_mark_start = 1'b0;
        scan           = SEEK_MARK;
        field_idx      = '0;
        mode_code      = MODE_UNKNOWN;
        for (int j = 0; j < CHANNELS; j++)
        begin
            levels[j] = '0;
        end
    endtask

    // Store one channel value, clamped to a percentage.
    task automatic store_level(input logic [7:0] b);
        if (field_idx < CHANNELS)
        begin
            levels[field_idx] = (b > LEVEL_MAX) ? LEVEL_MAX[6:0] : b[6:0];
            field_idx = field_idx + 3'd1;
        end
        scan = (field_idx >= CHANNELS) ? FIELDS_DONE : WANT_ID;
    endtask

    // Advance the predictor by one accepted byte; on the final byte of a
    // packet the classified reply joins the expected queue.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [3:0] pos;
        logic [3:0] hits;
        reply_t     want;
        int         level_sum;

        pos  = pos_count;
        hits = prefix_hits;
        case (pos)
            4'd0:
            begin
                if (b != BYTE_HEAD) hits = '0;
            end
            4'd1:
            begin
                if (b != BYTE_ACK)
                begin
                    hits[HIT_MANUAL] = 1'b0;
                    hits[HIT_AUTO]   = 1'b0;
                end
                if (b != BYTE_CHANNEL_ACK) hits[HIT_CHANNEL] = 1'b0;
                if (b != BYTE_STATUS) hits[HIT_STATUS] = 1'b0;
            end
            4'd2:
            begin
                if (b != BYTE_ONE)
                begin
                    hits[HIT_MANUAL] = 1'b0;
                    hits[HIT_AUTO]   = 1'b0;
                end
                if (b != BYTE_ZERO) hits[HIT_STATUS] = 1'b0;
            end
            4'd3:
            begin
                if (b != BYTE_ZERO) hits[HIT_MANUAL] = 1'b0;
                if (b != BYTE_ONE) hits[HIT_AUTO] = 1'b0;
                if (b != BYTE_STATUS_LEN) hits[HIT_STATUS] = 1'b0;
            end
            4'd4:
            begin
                if (b != BYTE_ONE) hits[HIT_STATUS] = 1'b0;
            end
            4'd5:
            begin
                if (b == BYTE_ZERO) mode_code = MODE_MANUAL;
                else if (b == BYTE_ONE) mode_code = MODE_AUTO;
                else mode_code = MODE_UNKNOWN;
            end
            default:
            begin
            end
        endcase
        prefix_hits = hits;
        pos = (pos < 4'd8) ? pos + 4'd1 : 4'd8;
        pos_count = pos;

        // Only the first marker opens the channel fields.
        case (scan)
            SEEK_MARK:
            begin
                if (saw_mark_start && b == BYTE_MARK_END)
                begin
                    scan      = WANT_ID;
                    field_idx = '0;
                end
                else
                begin
                    saw_mark_start = (b == BYTE_MARK_START);
                end
            end
            WANT_ID:
            begin
                if (field_idx < CHANNELS && b == BYTE_FIRST_ID + field_idx) scan = AFTER_ID;
                else scan = FIELDS_BAD;
            end
            AFTER_ID:
            begin
                if (b == BYTE_VALUE_TAG) scan = WANT_VALUE;
                else store_level(b);
            end
            WANT_VALUE:
            begin
                store_level(b);
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            want = '0;
            if (pos >= 4'd4)
            begin
                if (hits[HIT_MANUAL]) want.reply_kind = KIND_MANUAL_ACK;
                else if (hits[HIT_AUTO]) want.reply_kind = KIND_AUTO_ACK;
                else if (hits[HIT_CHANNEL]) want.reply_kind = KIND_CHANNEL_ACK;
                else if (hits[HIT_STATUS] && pos >= 4'd5) want.reply_kind = KIND_STATUS;
            end
            // Channel data is reported only for status replies of eight bytes or more.
            if (want.reply_kind == KIND_STATUS && pos >= 4'd8)
            begin
                level_sum = 0;
                for (int j = 0; j < CHANNELS; j++)
                begin
                    level_sum += levels[j];
                end
                want.status_ok        = (scan == FIELDS_DONE);
                want.light_mode       = mode_code;
                want.pink_level       = levels[0];
                want.blue_level       = levels[1];
                want.cold_white_level = levels[2];
                want.white_level      = levels[3];
                want.warm_white_level = levels[4];
                if (want.status_ok) want.average_level = 7'((level_sum + 2) / CHANNELS);
            end
            expected_replies.push_back(want);
            clear_scan();
        end
    endtask

    // Print one line per failure and count it.
    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("reply %0d %s: got %0d, expected %0d",
                                   replies_checked, name, got, want));
    endtask

    // Compare an accepted reply with the oldest prediction.
    task automatic check_reply();
        reply_t want;

        if (expected_replies.size() == 0)
        begin
            report_error($sformatf("reply of kind %0d arrived with none expected",
                                   reply_ch.reply_kind));
        end
        else
        begin
            want = expected_replies.pop_front();
            compare_field("reply_kind", reply_ch.reply_kind, want.reply_kind);
            compare_field("status_ok", reply_ch.status_ok, want.status_ok);
            compare_field("light_mode", reply_ch.light_mode, want.light_mode);
            compare_field("pink_level", reply_ch.pink_level, want.pink_level);
            compare_field("blue_level", reply_ch.blue_level, want.blue_level);
            compare_field("cold_white_level", reply_ch.cold_white_level,
                          want.cold_white_level);
            compare_field("white_level", reply_ch.white_level, want.white_level);
            compare_field("warm_white_level", reply_ch.warm_white_level,
                          want.warm_white_level);
            compare_field("average_level", reply_ch.average_level, want.average_level);
            if (want.status_ok) complete_status++;
        end
        replies_checked++;
    endtask

    // Move the scratch packet into the send queue, marking its last byte.
    task automatic emit_packet();
        rx_item_t item;

        for (int i = 0; i < pkt.size(); i++)
        begin
            item.rx_byte       = pkt[i];
            item.end_of_packet = (i == pkt.size() - 1);
            pending_bytes.push_back(item);
        end
        pkt.delete();
        packets_built++;
    endtask

    task automatic add_status_head(input logic [7:0] mode_byte);
        pkt.push_back(BYTE_HEAD);
        pkt.push_back(BYTE_STATUS);
        pkt.push_back(BYTE_ZERO);
        pkt.push_back(BYTE_STATUS_LEN);
        pkt.push_back(BYTE_ONE);
        pkt.push_back(mode_byte);
    endtask

    task automatic add_field(input logic [7:0] id, input logic with_tag,
                             input logic [7:0] value);
        pkt.push_back(id);
        if (with_tag) pkt.push_back(BYTE_VALUE_TAG);
        pkt.push_back(value);
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 9))
            0: return LEVEL_MAX;
            1: return LEVEL_MAX + 8'd1;
            2, 3: return 8'($urandom_range(101, 255));
            default: return 8'($urandom_range(0, 100));
        endcase
    endfunction

    // A status reply with random mode, filler, fields and trailer; a few
    // carry a bad id or are cut short.
    task automatic build_status();
        logic [7:0] mode_byte;
        logic [7:0] id;
        int         keep;

        case ($urandom_range(0, 3))
            0: mode_byte = BYTE_ZERO;
            1: mode_byte = BYTE_ONE;
            2: mode_byte = BYTE_MARK_START;
            default: mode_byte = 8'($urandom);
        endcase
        add_status_head(mode_byte);
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        pkt.push_back(BYTE_MARK_START);
        pkt.push_back(BYTE_MARK_END);
        for (int k = 0; k < CHANNELS; k++)
        begin
            id = BYTE_FIRST_ID + 8'(k);
            if ($urandom_range(0, 24) == 0) id = 8'($urandom);
            add_field(id, 1'($urandom), random_level());
        end
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0)
        begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
        emit_packet();
    endtask

    // One of the three acks, sometimes with a corrupted byte.
    task automatic build_ack();
        pkt.push_back(BYTE_HEAD);
        case ($urandom_range(0, 2))
            0:
            begin
                pkt.push_back(BYTE_ACK);
                pkt.push_back(BYTE_ONE);
                pkt.push_back(BYTE_ZERO);
            end
            1:
            begin
                pkt.push_back(BYTE_ACK);
                pkt.push_back(BYTE_ONE);
                pkt.push_back(BYTE_ONE);
            end
            default:
            begin
                pkt.push_back(BYTE_CHANNEL_ACK);
                pkt.push_back(8'($urandom));
                pkt.push_back(8'($urandom));
            end
        endcase
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        if ($urandom_range(0, 6) == 0) pkt[$urandom_range(0, 3)] = 8'($urandom);
        emit_packet();
    endtask

    // Random bytes, often behind a valid head byte.
    task automatic build_noise();
        repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) pkt[0] = BYTE_HEAD;
        emit_packet();
    endtask

    // Accept bytes, predict replies and check the replies that arrive.
    always @(posedge clk)
    begin
        byte_taken <= rx_ch.valid && rx_ch.ready;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready) absorb_byte(rx_ch.rx_byte, rx_ch.end_of_packet);
            if (reply_ch.valid && reply_ch.ready) check_reply();
        end
    end

    // Byte driver: holds an item until it is taken, idles in bursts.
    always @(negedge clk)
    begin
        if (!rst_n || (rx_ch.valid && !byte_taken))
        begin
        end
        else if (send_gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end
        else if (pending_bytes.size() == 0)
        begin
            rx_ch.valid <= 1'b0;
        end
        else if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
        begin
            rx_ch.valid <= 1'b0;
            send_gap    <= $urandom_range(0, 6);
        end
        else
        begin
            next_item = pending_bytes.pop_front();
            rx_ch.valid         <= 1'b1;
            rx_ch.rx_byte       <= next_item.rx_byte;
            rx_ch.end_of_packet <= next_item.end_of_packet;
        end
    end

    // Reply receiver: stalls in bursts except near the end.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
        end
        else if (stall_left > 0)
        begin
            reply_ch.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
        begin
            reply_ch.ready <= 1'b0;
            stall_left     <= $urandom_range(0, 6);
        end
        else
        begin
            reply_ch.ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int first_random;
        int pick;

        rst_n                = 1'b0;
        rx_ch.valid          = 1'b0;
        rx_ch.rx_byte        = '0;
        rx_ch.end_of_packet  = 1'b0;
        reply_ch.ready       = 1'b0;
        byte_taken           = 1'b0;
        send_gap             = 0;
        stall_left           = 0;
        error_count          = 0;
        packets_built        = 0;
        replies_checked      = 0;
        complete_status      = 0;
        clear_scan();

        // Directed: each ack kind, short packets, a one-byte packet.
        pkt = '{BYTE_HEAD, BYTE_ACK, BYTE_ONE, BYTE_ZERO};
        emit_packet();
        pkt = '{BYTE_HEAD, BYTE_ACK, BYTE_ONE, BYTE_ONE, 8'hff};
        emit_packet();
        pkt = '{BYTE_HEAD, BYTE_CHANNEL_ACK, 8'h55, 8'haa};
        emit_packet();
        pkt = '{BYTE_HEAD, BYTE_ACK, BYTE_ONE};
        emit_packet();
        pkt = '{8'hff};
        emit_packet();
        // Status header alone, then a status reply too short for channel data.
        pkt = '{BYTE_HEAD, BYTE_STATUS, BYTE_ZERO, BYTE_STATUS_LEN, BYTE_ONE};
        emit_packet();
        add_status_head(BYTE_ONE);
        pkt.push_back(BYTE_MARK_START);
        emit_packet();
        // Complete status: both field forms, values at and above the clamp.
        add_status_head(BYTE_ONE);
        pkt.push_back(BYTE_MARK_START);
        pkt.push_back(BYTE_MARK_END);
        add_field(BYTE_FIRST_ID, 1'b1, 8'd0);
        add_field(BYTE_FIRST_ID + 8'd1, 1'b0, 8'd100);
        add_field(BYTE_FIRST_ID + 8'd2, 1'b1, 8'd101);
        add_field(BYTE_FIRST_ID + 8'd3, 1'b0, 8'hff);
        add_field(BYTE_FIRST_ID + 8'd4, 1'b1, 8'h7f);
        pkt.push_back(BYTE_MARK_START);
        pkt.push_back(BYTE_MARK_END);
        emit_packet();
        // Wrong id on the second field: the first channel is kept.
        add_status_head(BYTE_ZERO);
        pkt.push_back(BYTE_MARK_START);
        pkt.push_back(BYTE_MARK_END);
        add_field(BYTE_FIRST_ID, 1'b0, 8'd50);
        add_field(BYTE_FIRST_ID + 8'd2, 1'b0, 8'd60);
        emit_packet();
        // No marker at all, mode byte neither manual nor automatic.
        add_status_head(BYTE_MARK_START);
        pkt.push_back(8'h00);
        pkt.push_back(8'h80);
        emit_packet();
        // Packet ends inside the channel fields.
        add_status_head(BYTE_ZERO);
        pkt.push_back(BYTE_MARK_START);
        pkt.push_back(BYTE_MARK_END);
        add_field(BYTE_FIRST_ID, 1'b1, 8'd20);
        pkt.push_back(BYTE_FIRST_ID + 8'd1);
        pkt.push_back(BYTE_VALUE_TAG);
        emit_packet();

        // Random part: mostly status replies, mixed with acks and noise.
        first_random = pending_bytes.size();
        while (pending_bytes.size() - first_random < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 11) build_status();
            else if (pick < 15) build_ack();
            else build_noise();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || rx_ch.valid) @(posedge clk);
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d packets; checked %0d replies.", packets_built, replies_checked);
        $display("Replies with all five channels parsed: %0d.", complete_status);
        if (error_count == 0)
            $display("light_reply_packet_parser regression: pass");
        else
            $display("light_reply_packet_parser regression: fail");
        $finish;
    end

    // Hard stop in case the parser hangs.
    initial
    begin
        #400000;
        $display("Timed out with %0d replies still expected.", expected_replies.size());
        $display("light_reply_packet_parser regression: fail");
        $finish;
    end

endmodule
